// ===== hw/rtl/rmwm_pkg.sv =====
// Package with payload types and constants for the RGB median/mean filter.
package rmwm_pkg;

    localparam int unsigned CHANNELS = 3;
    localparam int unsigned CELLS = 9;
    localparam int unsigned POS_BITS = 6;
    localparam logic [POS_BITS-1:0] FULL_LAST = 6'd32;
    localparam logic [POS_BITS-1:0] INCR_LAST = 6'd14;

    // Divide by ten as (x * RECIP_TEN) >> RECIP_SHIFT, exact for x below 2**22.
    localparam int unsigned RECIP_TEN = 838861;
    localparam int unsigned RECIP_SHIFT = 23;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       new_row;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;

    // Window action decoded from the group position.
    typedef enum logic [2:0] {
        ACT_STORE     = 3'd0,
        ACT_COL_LEFT  = 3'd1,
        ACT_COL_RIGHT = 3'd2,
        ACT_ROW       = 3'd3
    } act_t;

    typedef struct packed {
        act_t       act;
        logic [3:0] slot;
        logic [1:0] row_sel;
        logic       shift_up;
        logic       take_med;
        logic [3:0] grid_idx;
        logic       grid_left;
        logic       done;
    } step_ctl_t;

endpackage

// ===== hw/rtl/rmwm_median9.sv =====
// Median of nine values for one channel, built from a compare-exchange network.
module rmwm_median9 #(
    parameter int unsigned W = 8
) (
    input  logic [9*W-1:0] vals,
    output logic [W-1:0]   med
);
    logic [W-1:0] v [9];
    logic [W-1:0] mx, mn, md;

    // Sort each triple, then take max of mins, min of maxes, median of medians.
    function automatic logic [3*W-1:0] sort3(input logic [W-1:0] a, b, c);
        logic [W-1:0] x, y, z, t;
        begin
            x = a; y = b; z = c;
            if (x > y) begin t = x; x = y; y = t; end
            if (y > z) begin t = y; y = z; z = t; end
            if (x > y) begin t = x; x = y; y = t; end
            sort3 = {x, y, z};
        end
    endfunction

    logic [3*W-1:0] r0, r1, r2, cmin, cmid, cmax, fin;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            v[i] = vals[i*W +: W];
        end
        r0 = sort3(v[0], v[1], v[2]);
        r1 = sort3(v[3], v[4], v[5]);
        r2 = sort3(v[6], v[7], v[8]);
        cmin = sort3(r0[3*W-1 -: W], r1[3*W-1 -: W], r2[3*W-1 -: W]);
        cmid = sort3(r0[2*W-1 -: W], r1[2*W-1 -: W], r2[2*W-1 -: W]);
        cmax = sort3(r0[W-1:0], r1[W-1:0], r2[W-1:0]);
        mx = cmin[W-1:0];
        md = cmid[2*W-1 -: W];
        mn = cmax[3*W-1 -: W];
        fin = sort3(mx, md, mn);
        med = fin[2*W-1 -: W];
    end
endmodule

// ===== hw/rtl/rgb_median_then_weighted_mean_filter_top.sv =====
// RGB median-then-weighted-mean filter: one word per cycle, one result per pixel group.
// Takes one input word every cycle while no skid word waits. A full group (new_row high
// on its first word) is 33 words, an incremental group 15. Each accepted word updates the
// 3x3 window and, where the serpentine path completes a window, a median-of-nine network
// writes one grid cell at the edge that takes the word. After the last word of a group, a
// mean stage reads the stored grid in the next cycle and loads the output register, or the
// skid word if the output stalls. A one-word skid behind the output register holds a
// finished result while the output stalls; the input stalls only while that skid word
// waits. The median grid resets to zero; the window needs no reset.
module rgb_median_then_weighted_mean_filter_top #(
    parameter int unsigned PIXEL_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rmwm_pkg::pix_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rmwm_pkg::pix_out_t out_data
);
    import rmwm_pkg::*;

    localparam int unsigned SUM_BITS = PIXEL_BITS + 4;
    localparam int unsigned PROD_BITS = SUM_BITS + 24;
    localparam int unsigned PW = PIXEL_BITS;

    logic [PW-1:0] win_reg [CHANNELS][CELLS];
    logic [PW-1:0] win_next [CHANNELS][CELLS];
    logic [PW-1:0] grid_reg [CHANNELS][CELLS];
    logic [PW-1:0] grid_next [CHANNELS][CELLS];
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic full_reg, full_next, full_cur;
    logic [PW-1:0] px [CHANNELS];
    logic [PW-1:0] med [CHANNELS];
    logic [9*PW-1:0] med_vals [CHANNELS];
    step_ctl_t ctl;
    logic accept;
    logic pend_reg, pend_next;
    logic res_load;
    logic res_valid_reg, res_valid_next;
    logic skid_valid_reg, skid_valid_next;
    pix_out_t res_reg, res_next, skid_reg;
    logic [7:0] mean_val [CHANNELS];
    logic [SUM_BITS-1:0] sum [CHANNELS];
    logic [PROD_BITS-1:0] prod [CHANNELS];

    assign in_ready = !skid_valid_reg;
    assign accept = in_valid && in_ready;
    assign full_cur = (pos_reg == '0) ? in_data.new_row : full_reg;

    always_comb
    begin
        logic [7:0] raw [CHANNELS];
        raw[0] = in_data.red_in;
        raw[1] = in_data.green_in;
        raw[2] = in_data.blue_in;
        for (int c = 0; c < CHANNELS; c++)
        begin
            px[c] = PW'(raw[c] & 8'((1 << (PW > 8 ? 8 : PW)) - 1));
        end
    end

    // Decode the group position into a window action and a grid target.
    always_comb
    begin
        logic [5:0] p, q;
        logic [1:0] w;
        logic [1:0] k;
        p = pos_reg;
        ctl = '0;
        ctl.act = ACT_STORE;
        q = '0;
        w = '0;
        k = '0;
        if (full_cur)
        begin
            if (p < 6'd9)
            begin
                ctl.slot = p[3:0];
                ctl.take_med = (p == 6'd8);
                ctl.grid_idx = 4'd0;
            end
            else if (p < 6'd15 || p >= 6'd27 || (p >= 6'd18 && p < 6'd24))
            begin
                if (p < 6'd15) q = p - 6'd9;
                else if (p < 6'd24) q = p - 6'd18;
                else q = p - 6'd27;
                w = (q >= 6'd3) ? 2'(q - 6'd3) : q[1:0];
                k = (q >= 6'd3) ? 2'd1 : 2'd0;
                ctl.row_sel = w;
                ctl.take_med = (w == 2'd2);
                if (p >= 6'd18 && p < 6'd24)
                begin
                    ctl.act = ACT_COL_RIGHT;
                    ctl.grid_idx = 4'd4 - {2'b0, k};
                end
                else
                begin
                    ctl.act = ACT_COL_LEFT;
                    ctl.grid_idx = ((p < 6'd15) ? 4'd1 : 4'd7) + {2'b0, k};
                end
                ctl.done = (p >= FULL_LAST);
            end
            else
            begin
                q = (p < 6'd18) ? p - 6'd15 : p - 6'd24;
                ctl.act = ACT_ROW;
                ctl.shift_up = (q == 6'd0);
                ctl.slot = 4'd6 + q[3:0];
                ctl.take_med = (q == 6'd2);
                ctl.grid_idx = (p < 6'd18) ? 4'd5 : 4'd6;
            end
        end
        else
        begin
            ctl.grid_left = (p == 6'd0);
            if (p < 6'd9)
            begin
                ctl.slot = p[3:0];
                ctl.take_med = (p == 6'd8);
                ctl.grid_idx = 4'd2;
            end
            else
            begin
                q = (p < 6'd12) ? p - 6'd9 : p - 6'd12;
                ctl.act = ACT_ROW;
                ctl.shift_up = (q == 6'd0);
                ctl.slot = 4'd6 + q[3:0];
                ctl.take_med = (q == 6'd2);
                ctl.grid_idx = (p < 6'd12) ? 4'd5 : 4'd8;
                ctl.done = (p >= INCR_LAST);
            end
        end
    end

    // Next window contents.
    always_comb
    begin
        logic [3:0] b;
        win_next = win_reg;
        b = 4'(ctl.row_sel) * 4'd3;
        for (int c = 0; c < CHANNELS; c++)
        begin
            unique case (ctl.act)
                ACT_STORE:
                begin
                    win_next[c][ctl.slot] = px[c];
                end
                ACT_COL_LEFT:
                begin
                    win_next[c][b]        = win_reg[c][b + 4'd1];
                    win_next[c][b + 4'd1] = win_reg[c][b + 4'd2];
                    win_next[c][b + 4'd2] = px[c];
                end
                ACT_COL_RIGHT:
                begin
                    win_next[c][b + 4'd2] = win_reg[c][b + 4'd1];
                    win_next[c][b + 4'd1] = win_reg[c][b];
                    win_next[c][b]        = px[c];
                end
                ACT_ROW:
                begin
                    if (ctl.shift_up)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            win_next[c][i] = win_reg[c][i + 3];
                        end
                    end
                    win_next[c][ctl.slot] = px[c];
                end
                default:
                begin
                    win_next[c][ctl.slot] = px[c];
                end
            endcase
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_med
        always_comb
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                med_vals[c][i*PW +: PW] = win_next[c][i];
            end
        end
        rmwm_median9 #(.W(PW)) u_med (.vals(med_vals[c]), .med(med[c]));
    end

    // Grid update.
    always_comb
    begin
        grid_next = grid_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (ctl.grid_left)
            begin
                for (int w = 0; w < 3; w++)
                begin
                    grid_next[c][3*w]     = grid_reg[c][3*w + 1];
                    grid_next[c][3*w + 1] = grid_reg[c][3*w + 2];
                end
            end
            if (ctl.take_med)
            begin
                grid_next[c][ctl.grid_idx] = med[c];
            end
        end
    end

    // Weighted mean over the stored grid; the divide by ten is a reciprocal multiply.
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum[c] = '0;
            for (int i = 0; i < CELLS; i++)
            begin
                sum[c] = sum[c] + SUM_BITS'(grid_reg[c][i]);
            end
            sum[c] = sum[c] + SUM_BITS'(grid_reg[c][4]);
            prod[c] = PROD_BITS'(sum[c]) * PROD_BITS'(RECIP_TEN);
            mean_val[c] = 8'((prod[c] >> RECIP_SHIFT) & PROD_BITS'((1 << PW) - 1));
        end
    end

    assign pos_next = ctl.done ? '0 : pos_reg + 1'b1;
    assign full_next = full_cur;
    assign res_next = '{red_out: mean_val[0], green_out: mean_val[1], blue_out: mean_val[2]};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            full_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    grid_reg[c][i] <= '0;
                end
            end
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            full_reg <= full_next;
            grid_reg <= grid_next;
        end
    end

    // pend_reg marks the cycle after a group's last word is taken, when the mean reads the grid.
    assign pend_next = accept && ctl.done;
    assign res_load = !res_valid_reg || out_ready;

    // Output register with one skid word behind it.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (res_load)
        begin
            res_valid_next = skid_valid_reg || pend_reg;
            skid_valid_next = 1'b0;
        end
        else if (pend_reg)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            res_valid_reg <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= skid_valid_reg ? skid_reg : res_next;
        end
        if (!res_load && pend_reg)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data = res_reg;
endmodule

// ===== hw/rtl/rmwm_checker.sv =====
// Port-level checker for the filter top, bound to every instance.
module rmwm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rmwm_pkg::pix_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("handshake output unknown");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result word out of reset");
endmodule

bind rgb_median_then_weighted_mean_filter_top rmwm_checker u_rmwm_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the RGB median-then-weighted-mean filter top level.
module tb_top;
    import rmwm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pix_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pix_out_t out_data;

    rgb_median_then_weighted_mean_filter_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #10 clk = ~clk;

    // Predictor state: pixel window, median grid, position in group, group mode.
    logic [7:0] win [9][3];
    logic [7:0] grid [9][3];
    int         grp_pos;
    bit         grp_full;
    pix_out_t   filtered_q[$];
    int         errors;
    int         words_sent;
    bit         idle_en;
    bit         hold_req;
    int         idle_count;

    task automatic take_median(input int idx);
        logic [7:0] t [9];
        logic [7:0] v;
        int j;
        for (int c = 0; c < 3; c++)
        begin
            for (int i = 0; i < 9; i++)
                t[i] = win[i][c];
            for (int i = 1; i < 9; i++)
            begin
                v = t[i];
                j = i;
                while (j > 0 && t[j-1] > v)
                begin
                    t[j] = t[j-1];
                    j--;
                end
                t[j] = v;
            end
            grid[idx % 9][c] = t[4];
        end
    endtask

    // A row slides one place and the new pixel enters at the freed edge.
    task automatic column_step(input int q, input bit to_left, input logic [2:0][7:0] px,
                               input int cell0, input bit up_cells);
        int w;
        int k;
        w = q % 3;
        k = q / 3;
        for (int c = 0; c < 3; c++)
        begin
            if (to_left)
            begin
                win[w*3][c]   = win[w*3+1][c];
                win[w*3+1][c] = win[w*3+2][c];
                win[w*3+2][c] = px[c];
            end
            else
            begin
                win[w*3+2][c] = win[w*3+1][c];
                win[w*3+1][c] = win[w*3][c];
                win[w*3][c]   = px[c];
            end
        end
        if (w == 2)
            take_median(up_cells ? cell0 + k : cell0 - k);
    endtask

    task automatic row_step(input int q, input logic [2:0][7:0] px, input int idx);
        if (q == 0)
            for (int i = 0; i < 6; i++)
                for (int c = 0; c < 3; c++)
                    win[i][c] = win[i+3][c];
        for (int c = 0; c < 3; c++)
            win[6+q][c] = px[c];
        if (q == 2)
            take_median(idx);
    endtask

    task automatic predict_filter(input pix_in_t w);
        logic [2:0][7:0] px;
        bit done;
        int p;
        int sum;
        pix_out_t r;
        px[0] = w.red_in;
        px[1] = w.green_in;
        px[2] = w.blue_in;
        p = grp_pos;
        done = 1'b0;
        if (p == 0)
            grp_full = w.new_row;
        if (grp_full)
        begin
            if (p < 9)
            begin
                for (int c = 0; c < 3; c++)
                    win[p][c] = px[c];
                if (p == 8)
                    take_median(0);
            end
            else if (p < 15)
                column_step(p - 9, 1'b1, px, 1, 1'b1);
            else if (p < 18)
                row_step(p - 15, px, 5);
            else if (p < 24)
                column_step(p - 18, 1'b0, px, 4, 1'b0);
            else if (p < 27)
                row_step(p - 24, px, 6);
            else
            begin
                column_step((p - 27) % 6, 1'b1, px, 7, 1'b1);
                done = (p >= FULL_LAST);
            end
        end
        else
        begin
            if (p == 0)
                for (int w3 = 0; w3 < 3; w3++)
                    for (int c = 0; c < 3; c++)
                    begin
                        grid[w3*3][c]   = grid[w3*3+1][c];
                        grid[w3*3+1][c] = grid[w3*3+2][c];
                    end
            if (p < 9)
            begin
                for (int c = 0; c < 3; c++)
                    win[p][c] = px[c];
                if (p == 8)
                    take_median(2);
            end
            else if (p < 12)
                row_step(p - 9, px, 5);
            else
            begin
                row_step((p - 12) % 3, px, 8);
                done = (p >= INCR_LAST);
            end
        end
        if (!done)
            grp_pos = p + 1;
        else
        begin
            grp_pos = 0;
            for (int c = 0; c < 3; c++)
            begin
                sum = 0;
                for (int i = 0; i < 9; i++)
                    sum += grid[i][c] * ((i == 4) ? 2 : 1);
                px[c] = 8'(sum / 10);
            end
            r.red_out = px[0];
            r.green_out = px[1];
            r.blue_out = px[2];
            filtered_q.push_back(r);
        end
    endtask

    task automatic send_word(input pix_in_t w);
        int gap;
        gap = idle_en ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        predict_filter(w);
        words_sent++;
    endtask

    function automatic logic [7:0] pick_channel(input int kind);
        case (kind)
            1: return 8'hff;
            2: return 8'h00;
            default:
            begin
                case ($urandom_range(0, 7))
                    0: return 8'h00;
                    1: return 8'hff;
                    default: return 8'($urandom);
                endcase
            end
        endcase
    endfunction

    // kind: 0 random content, 1 all maximum, 2 all zero.
    task automatic send_group(input bit full, input int kind);
        pix_in_t w;
        int len;
        len = full ? 33 : 15;
        for (int i = 0; i < len; i++)
        begin
            w.red_in = pick_channel(kind);
            w.green_in = pick_channel(kind);
            w.blue_in = pick_channel(kind);
            // Only the first word of a group carries the mode; later flags are noise.
            w.new_row = (i == 0) ? full : 1'($urandom);
            send_word(w);
        end
    endtask

    task automatic test_incremental_from_reset();
        send_group(1'b0, 0);
    endtask

    task automatic test_extremes();
        send_group(1'b1, 1);
        send_group(1'b0, 2);
        send_group(1'b1, 2);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int g = 0; g < 4; g++)
            send_group(1'b0, 0);
    endtask

    task automatic test_drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        send_group(1'b1, 0);
        send_group(1'b0, 0);
    endtask

    task automatic test_random_groups();
        while (words_sent < 900)
        begin
            if ($urandom_range(0, 3) == 0)
                idle_en = ~idle_en;
            send_group($urandom_range(0, 2) == 0, 0);
        end
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = idle_en ? $urandom_range(0, 16) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (filtered_q.size() == 0)
            begin
                $error("unexpected result word %h", out_data);
                errors++;
            end
            else
            begin
                pix_out_t e;
                e = filtered_q.pop_front();
                if (out_data.red_out !== e.red_out)
                begin
                    $error("red_out expected %0d actual %0d", e.red_out, out_data.red_out);
                    errors++;
                end
                if (out_data.green_out !== e.green_out)
                begin
                    $error("green_out expected %0d actual %0d", e.green_out,
                           out_data.green_out);
                    errors++;
                end
                if (out_data.blue_out !== e.blue_out)
                begin
                    $error("blue_out expected %0d actual %0d", e.blue_out, out_data.blue_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else if (idle_count + 1 >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
            idle_count <= idle_count + 1;
    end

    initial
    begin
        int drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        errors = 0;
        words_sent = 0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        idle_count = 0;
        grp_pos = 0;
        grp_full = 1'b0;
        for (int i = 0; i < 9; i++)
            for (int c = 0; c < 3; c++)
            begin
                grid[i][c] = '0;
                win[i][c] = '0;
            end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_incremental_from_reset();
        test_extremes();
        test_backpressure();
        test_drain_pause();
        test_random_groups();

        in_valid <= 1'b0;
        drain = 0;
        while (filtered_q.size() != 0 && drain < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && filtered_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
